// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/pfba_pkg.sv =====
// ---------------------------------------------------------------------------
// pfba_pkg
// Types and constants shared by the page frame bitmap allocator.
// ---------------------------------------------------------------------------
package pfba_pkg;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RESERVE = 1'b1;

    localparam logic [7:0] BYTE_FULL = 8'hFF;

    typedef struct packed {
        logic        action;
        logic [11:0] start_frame;
        logic [12:0] frame_count;
    } t_in;

    typedef struct packed {
        logic [11:0] frame_index;
        logic        found;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic setup;
        logic mark;
        logic resp;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic miss;
        logic skip;
        logic mark_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/page_frame_bitmap_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// page_frame_bitmap_allocator_unit
// Page frame bitmap allocator: allocate lowest free frame or reserve a run.
// ---------------------------------------------------------------------------
// One bit per frame, eight frames per byte of a bitmap memory with one
// write and one read port, (FRAME_COUNT+7)/8 bytes, 1 = used. After reset
// the block runs a clearing pass that writes one byte a cycle, with
// o_in_ready low. An allocate beat scans the bitmap one byte a cycle for
// the lowest clear bit, returns its frame and marks frame_count frames
// from it; a reserve beat marks frame_count frames from start_frame.
// Marking is a read-modify-write stream of one byte a cycle, clipped at
// the last frame. With S the bytes scanned (allocate only) and M the bytes
// marked, marking starts at the byte where the scan stopped, so S + M stays
// within (FRAME_COUNT+7)/8 + 1, 513 at the default. Items are taken one at
// a time, and the response waits while the result register is full and
// i_out_ready is low. One result beat per item; the result sits in an
// output register so a new item can be accepted while it waits.
// ---------------------------------------------------------------------------
module page_frame_bitmap_allocator_unit #(
    parameter int FRAME_COUNT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pfba_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pfba_pkg::t_out   o_out_data
);

    pfba_pkg::t_dp_cmd  cmd;
    pfba_pkg::t_dp_stat stat;

    // sequencer
    pfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // bitmap, counters, result register
    pfba_dp #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/pfba_ctrl.sv =====
// ---------------------------------------------------------------------------
// pfba_ctrl
// Sequencer: clear pass, scan, run setup, mark, response.
// ---------------------------------------------------------------------------
module pfba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_action,
    input  pfba_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output pfba_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SETUP = 6'b001000,
        S_MARK  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_action == pfba_pkg::ACT_RESERVE) ? S_SETUP : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_SETUP;
                end else if (i_stat.miss) begin
                    n_state = S_RESP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_stat.skip ? S_RESP : S_MARK;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_stat.mark_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/pfba_dp.sv =====
// ---------------------------------------------------------------------------
// pfba_dp
// Bitmap memory, address counters, run bounds and result register.
// ---------------------------------------------------------------------------
module pfba_dp #(
    parameter int FRAME_COUNT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfba_pkg::t_dp_cmd  i_cmd,
    input  pfba_pkg::t_in      i_in_data,
    input  logic               i_out_ready,
    output pfba_pkg::t_dp_stat o_stat,
    output logic               o_out_valid,
    output pfba_pkg::t_out     o_out_data
);

    localparam int MAP_BYTES = (FRAME_COUNT + 7) / 8;
    localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int FW        = $clog2(FRAME_COUNT);
    localparam int SW        = ((FW > 13) ? FW : 13) + 1;

    localparam logic [AW-1:0] LAST_ADDR  = AW'(MAP_BYTES - 1);
    localparam logic [SW-1:0] FRAMES     = SW'(FRAME_COUNT);
    localparam logic [SW-1:0] LAST_FRAME = SW'(FRAME_COUNT - 1);

    // lowest clear bit of a byte that is not full
    function automatic logic [2:0] low_zero(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (!v[k]) begin
                idx = 3'(k);
            end
        end
        return idx;
    endfunction

    logic [7:0]    mem [MAP_BYTES];

    pfba_pkg::t_in r_item;
    logic [AW-1:0] r_addr;
    logic          r_issue;
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    logic [7:0]    r_rd_data;
    logic [SW-1:0] r_first;
    logic [SW-1:0] r_last;
    logic          r_found;
    logic          r_out_valid;
    pfba_pkg::t_out r_out_data;

    logic          rd_en;
    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;
    logic [AW-1:0] first_byte;
    logic [AW-1:0] last_byte;
    logic [2:0]    lo;
    logic [2:0]    hi;
    logic [7:0]    mask;
    logic [SW-1:0] run_end;
    logic          byte_full;

    assign first_byte = r_first[AW+2:3];
    assign last_byte  = r_last[AW+2:3];
    assign byte_full  = (r_rd_data == pfba_pkg::BYTE_FULL);

    assign lo   = (r_pend_addr == first_byte) ? r_first[2:0] : 3'd0;
    assign hi   = (r_pend_addr == last_byte)  ? r_last[2:0]  : 3'd7;
    assign mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));

    assign run_end = r_first + SW'(r_item.frame_count) - SW'(1);

    assign rd_en = (i_cmd.scan || i_cmd.mark) && r_issue;
    assign we    = i_cmd.clr || (i_cmd.mark && r_pend);
    assign wa    = i_cmd.clr ? r_addr : r_pend_addr;
    assign wd    = i_cmd.clr ? 8'h00 : (r_rd_data | mask);

    always_comb begin
        o_stat           = '0;
        o_stat.clr_last  = (r_addr == LAST_ADDR);
        o_stat.hit       = r_pend && !byte_full;
        o_stat.miss      = r_pend && byte_full && (r_pend_addr == LAST_ADDR);
        o_stat.skip      = (r_first >= FRAMES) || (r_item.frame_count == 13'd0);
        o_stat.mark_last = r_pend && (r_pend_addr == last_byte);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // bitmap store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // address and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_addr <= r_addr + AW'(1);
            end else if (i_cmd.load) begin
                r_addr  <= '0;
                r_issue <= 1'b1;
                r_pend  <= 1'b0;
            end else if (i_cmd.setup) begin
                r_addr  <= first_byte;
                r_issue <= 1'b1;
                r_pend  <= 1'b0;
            end else if (i_cmd.scan || i_cmd.mark) begin
                r_pend <= r_issue;
                if (r_issue) begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == (i_cmd.scan ? LAST_ADDR : last_byte)) begin
                        r_issue <= 1'b0;
                    end
                end
            end
        end
    end

    // run bounds and item
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pend_addr <= r_addr;
        end
        if (i_cmd.load) begin
            r_item  <= i_in_data;
            r_first <= SW'(i_in_data.start_frame);
            r_found <= (i_in_data.action == pfba_pkg::ACT_RESERVE);
        end
        if (i_cmd.scan && o_stat.hit) begin
            r_first <= SW'({r_pend_addr, low_zero(r_rd_data)});
        end
        if (i_cmd.setup) begin
            r_last <= (run_end > LAST_FRAME) ? LAST_FRAME : run_end;
            if (r_item.action == pfba_pkg::ACT_ALLOC) begin
                r_found <= (r_first < FRAMES);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_out_data.found       <= r_found;
            r_out_data.frame_index <=
                (r_found && (r_item.action == pfba_pkg::ACT_ALLOC)) ? r_first[11:0] : 12'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/pfba_checker.sv =====
// ---------------------------------------------------------------------------
// pfba_checker
// Port-level checks for the page frame bitmap allocator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfba_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input pfba_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input pfba_pkg::t_out o_out_data
);

    // stalled result beat holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_data))

    // a failed allocate reports frame zero
    `ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found |-> o_out_data.frame_index == 12'd0)

    // one item at a time
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

    // clearing pass follows reset
    `ASSERT_CLK_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !o_in_ready)

endmodule

bind page_frame_bitmap_allocator_unit pfba_checker u_pfba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
